// ===== rtl/res_pkg.sv =====
// Shared types, constants and result widths for the ring entry store.
package res_pkg;

    localparam int DEF_DEPTH       = 10;
    localparam int DEF_SIZE_BITS   = 16;
    localparam int DEF_HANDLE_BITS = 32;

    localparam int OFFSET_IN_BITS  = 20;
    localparam int TOTAL_BITS      = 20;
    localparam int HANDLE_OUT_BITS = 32;
    localparam int OFFSET_OUT_BITS = 16;
    localparam int SLOT_OUT_BITS   = 4;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_CLR,
        ALU_SUB_OLD,
        ALU_ADD_NEW,
        ALU_STEP,
        ALU_OFFS
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    drop_old;
    } t_alu_ctl;

endpackage

// ===== rtl/res_mem.sv =====
// Entry storage: size and handle arrays, one write port, one registered read port.
module res_mem #(
    parameter int DEPTH       = res_pkg::DEF_DEPTH,
    parameter int SIZE_BITS   = res_pkg::DEF_SIZE_BITS,
    parameter int HANDLE_BITS = res_pkg::DEF_HANDLE_BITS,
    parameter int ADDR_BITS   = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_BITS-1:0]   i_waddr,
    input  logic [SIZE_BITS-1:0]   i_wsize,
    input  logic [HANDLE_BITS-1:0] i_whandle,
    input  logic [ADDR_BITS-1:0]   i_raddr,
    output logic [SIZE_BITS-1:0]   o_rsize,
    output logic [HANDLE_BITS-1:0] o_rhandle
);
    import res_pkg::*;

    logic [SIZE_BITS-1:0]   mem_size   [DEPTH];
    logic [HANDLE_BITS-1:0] mem_handle [DEPTH];
    logic [SIZE_BITS-1:0]   r_rsize;
    logic [HANDLE_BITS-1:0] r_rhandle;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_size[i_waddr]   <= i_wsize;
            mem_handle[i_waddr] <= i_whandle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsize   <= mem_size[i_raddr];
        r_rhandle <= mem_handle[i_raddr];
    end

    assign o_rsize   = r_rsize;
    assign o_rhandle = r_rhandle;

endmodule

// ===== rtl/res_walk.sv =====
// Shared add/subtract and compare unit with the running total and walk accumulator.
module res_walk #(
    parameter int DEPTH     = res_pkg::DEF_DEPTH,
    parameter int SIZE_BITS = res_pkg::DEF_SIZE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  res_pkg::t_alu_ctl                    i_ctl,
    input  logic [SIZE_BITS-1:0]                 i_rd_size,
    input  logic [SIZE_BITS-1:0]                 i_new_size,
    input  logic [res_pkg::OFFSET_IN_BITS-1:0]   i_target,
    output logic                                 o_lt,
    output logic [res_pkg::OFFSET_OUT_BITS-1:0]  o_offset,
    output logic [res_pkg::TOTAL_BITS-1:0]       o_total
);
    import res_pkg::*;

    localparam int EXACT_BITS = SIZE_BITS + $clog2(DEPTH + 1);
    localparam int SUM_BITS   = (EXACT_BITS > OFFSET_IN_BITS) ? EXACT_BITS : OFFSET_IN_BITS;

    logic [SUM_BITS-1:0] r_total, n_total;
    logic [SUM_BITS-1:0] r_cum, n_cum;
    logic [SUM_BITS-1:0] op_a, op_b, sum, target_x;
    logic                sub;

    assign target_x = SUM_BITS'(i_target);

    always_comb begin
        op_a = r_cum;
        op_b = '0;
        sub  = 1'b0;
        case (i_ctl.op)
            ALU_SUB_OLD: begin
                op_a = r_total;
                op_b = i_ctl.drop_old ? SUM_BITS'(i_rd_size) : '0;
                sub  = 1'b1;
            end
            ALU_ADD_NEW: begin
                op_a = r_total;
                op_b = SUM_BITS'(i_new_size);
            end
            ALU_STEP: begin
                op_a = r_cum;
                op_b = SUM_BITS'(i_rd_size);
            end
            ALU_OFFS: begin
                op_a = target_x;
                op_b = r_cum;
                sub  = 1'b1;
            end
            default: begin
                op_a = r_cum;
                op_b = '0;
            end
        endcase
    end

    assign sum  = op_a + (sub ? ~op_b : op_b) + SUM_BITS'(sub);
    assign o_lt = target_x < sum;

    always_comb begin
        n_total = r_total;
        n_cum   = r_cum;
        case (i_ctl.op)
            ALU_SUB_OLD, ALU_ADD_NEW: n_total = sum;
            ALU_CLR:                  n_cum   = '0;
            // keep the sum before the hit entry for the offset step
            ALU_STEP:                 n_cum   = o_lt ? r_cum : sum;
            default:                  n_cum   = r_cum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum <= n_cum;
    end

    assign o_offset = OFFSET_OUT_BITS'(sum);
    assign o_total  = (r_total > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(r_total);

endmodule

// ===== rtl/ring_entry_store_offset_lookup.sv =====
// Top level: ring entry store with byte-offset lookup and its sequencer.
//
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_kind, i_entry_size, i_entry_handle,
//                                              i_char_offset
//   result    out         o_valid / i_stall    o_hit, o_handle_out, o_byte_offset,
//                                              o_slot_out, o_total_bytes
//
// An add steps through accept, drop old size, add new size and write, and finish.
// A find walks the stored entries from the oldest, one entry per cycle through the
// shared adder and the single read port of the entry store; a hit takes the offset
// step before finish, and a full miss or an empty ring goes straight to finish.
// Reset is synchronous and clears the ring pointers, count, total and sequencer.
// A stalled result holds in the output register; the next item is taken while it waits.
module ring_entry_store_offset_lookup #(
    parameter int DEPTH       = res_pkg::DEF_DEPTH,
    parameter int SIZE_BITS   = res_pkg::DEF_SIZE_BITS,
    parameter int HANDLE_BITS = res_pkg::DEF_HANDLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic [SIZE_BITS-1:0]                 i_entry_size,
    input  logic [HANDLE_BITS-1:0]               i_entry_handle,
    input  logic [res_pkg::OFFSET_IN_BITS-1:0]   i_char_offset,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic [res_pkg::HANDLE_OUT_BITS-1:0]  o_handle_out,
    output logic [res_pkg::OFFSET_OUT_BITS-1:0]  o_byte_offset,
    output logic [res_pkg::SLOT_OUT_BITS-1:0]    o_slot_out,
    output logic [res_pkg::TOTAL_BITS-1:0]       o_total_bytes
);
    import res_pkg::*;

    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ADD_SUB = 6'b000010,
        S_ADD_NEW = 6'b000100,
        S_WALK    = 6'b001000,
        S_OFFS    = 6'b010000,
        S_FIN     = 6'b100000
    } t_state;

    function automatic logic [ADDR_BITS-1:0] next_slot(input logic [ADDR_BITS-1:0] s);
        next_slot = (s == ADDR_BITS'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    t_state                     r_state, n_state;
    logic [ADDR_BITS-1:0]       r_wslot, r_rslot, r_idx;
    logic [CNT_BITS-1:0]        r_count, r_left;
    logic [SIZE_BITS-1:0]       r_size;
    logic [HANDLE_BITS-1:0]     r_handle_in;
    logic [OFFSET_IN_BITS-1:0]  r_target;
    logic                       r_hit;
    logic [HANDLE_OUT_BITS-1:0] r_res_handle;
    logic [OFFSET_OUT_BITS-1:0] r_res_off;
    logic [SLOT_OUT_BITS-1:0]   r_res_slot;

    logic                       r_out_valid;
    logic                       r_o_hit;
    logic [HANDLE_OUT_BITS-1:0] r_o_handle;
    logic [OFFSET_OUT_BITS-1:0] r_o_off;
    logic [SLOT_OUT_BITS-1:0]   r_o_slot;
    logic [TOTAL_BITS-1:0]      r_o_total;

    logic                       full, in_take, out_take, load;
    logic [ADDR_BITS-1:0]       rd_addr;
    logic [SIZE_BITS-1:0]       rd_size;
    logic [HANDLE_BITS-1:0]     rd_handle;
    logic                       lt;
    logic [OFFSET_OUT_BITS-1:0] offset;
    logic [TOTAL_BITS-1:0]      total_sat;
    t_alu_ctl                   ctl;

    assign full     = (r_count == CNT_BITS'(DEPTH));
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign load     = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = (i_kind == KIND_FIND) ? r_rslot : r_wslot;
            S_WALK:  rd_addr = next_slot(r_idx);
            default: rd_addr = r_idx;
        endcase
    end

    always_comb begin
        ctl.drop_old = full;
        case (r_state)
            S_IDLE:    ctl.op = (in_take && i_kind == KIND_FIND) ? ALU_CLR : ALU_HOLD;
            S_ADD_SUB: ctl.op = ALU_SUB_OLD;
            S_ADD_NEW: ctl.op = ALU_ADD_NEW;
            S_WALK:    ctl.op = ALU_STEP;
            S_OFFS:    ctl.op = ALU_OFFS;
            default:   ctl.op = ALU_HOLD;
        endcase
    end

    res_mem #(
        .DEPTH       (DEPTH),
        .SIZE_BITS   (SIZE_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (r_state == S_ADD_NEW),
        .i_waddr   (r_wslot),
        .i_wsize   (r_size),
        .i_whandle (r_handle_in),
        .i_raddr   (rd_addr),
        .o_rsize   (rd_size),
        .o_rhandle (rd_handle)
    );

    res_walk #(
        .DEPTH     (DEPTH),
        .SIZE_BITS (SIZE_BITS)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_rd_size  (rd_size),
        .i_new_size (r_size),
        .i_target   (r_target),
        .o_lt       (lt),
        .o_offset   (offset),
        .o_total    (total_sat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_kind == KIND_ADD) begin
                        n_state = S_ADD_SUB;
                    end else if (r_count == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_ADD_SUB: n_state = S_ADD_NEW;
            S_ADD_NEW: n_state = S_FIN;
            S_WALK: begin
                if (lt) begin
                    n_state = S_OFFS;
                end else if (r_left == CNT_BITS'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_OFFS:  n_state = S_FIN;
            S_FIN:   n_state = load ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ADD_NEW) begin
                r_wslot <= next_slot(r_wslot);
                if (full) begin
                    r_rslot <= next_slot(r_wslot);
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_size       <= i_entry_size;
                    r_handle_in  <= i_entry_handle;
                    r_target     <= i_char_offset;
                    r_idx        <= rd_addr;
                    r_left       <= r_count;
                    r_hit        <= 1'b0;
                    r_res_handle <= '0;
                    r_res_off    <= '0;
                    r_res_slot   <= '0;
                end
            end
            S_ADD_SUB: begin
                r_hit        <= full;
                r_res_handle <= full ? HANDLE_OUT_BITS'(rd_handle) : '0;
                r_res_slot   <= SLOT_OUT_BITS'(r_wslot);
            end
            S_WALK: begin
                if (lt) begin
                    r_hit        <= 1'b1;
                    r_res_handle <= HANDLE_OUT_BITS'(rd_handle);
                    r_res_slot   <= SLOT_OUT_BITS'(r_idx);
                end else begin
                    // advance to the next newer entry
                    r_idx  <= next_slot(r_idx);
                    r_left <= r_left - 1'b1;
                end
            end
            S_OFFS: r_res_off <= offset;
            default: begin
                r_idx <= r_idx;
            end
        endcase
        if (load) begin
            r_o_hit    <= r_hit;
            r_o_handle <= r_res_handle;
            r_o_off    <= r_res_off;
            r_o_slot   <= r_res_slot;
            r_o_total  <= total_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_handle_out  = r_o_handle;
    assign o_byte_offset = r_o_off;
    assign o_slot_out    = r_o_slot;
    assign o_total_bytes = r_o_total;

endmodule
